FILE: rtl/agm_pkg.sv
// ============================================================================
// agm_pkg: shared types and constants for the audio glitch monitor
// Field widths, register indexes, enable bit positions, reset values and the
// control bundles passed between the monitor's submodules.
// ============================================================================
`default_nettype none

package agm_pkg;

    localparam int CH_W       = 3;   // channel field
    localparam int VAL_W      = 26;  // signed Q3.22 sample
    localparam int MAG_W      = 25;  // saturated magnitude
    localparam int RATIO_W    = 16;  // Q8.8 level ratio
    localparam int RATIO_FRAC = 8;
    localparam int POWER_W    = 50;  // Q6.44 dropout power
    localparam int MASK_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 50;

    localparam logic [MAG_W-1:0] VAL_MAX   = '1;
    localparam logic [MAG_W-1:0] MAG_RESET = 25'd42;

    // enable_mask bit positions
    localparam int EN_JUMP   = 0;
    localparam int EN_NONFIN = 1;
    localparam int EN_DC     = 2;
    localparam int EN_CLIP   = 3;
    localparam int EN_LEVEL  = 4;
    localparam int EN_DROP   = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE  = 3'd0,
        REG_JUMP    = 3'd1,
        REG_CLIP    = 3'd2,
        REG_DC      = 3'd3,
        REG_LEVEL   = 3'd4,
        REG_DROPOUT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [MASK_W-1:0]  enable_mask;
        logic [MAG_W-1:0]   jump_limit;
        logic [MAG_W-1:0]   clip_limit;
        logic [MAG_W-1:0]   dc_limit;
        logic [RATIO_W-1:0] level_ratio;
        logic [POWER_W-1:0] dropout_power;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        enable_mask:   6'd63,
        jump_limit:    25'd2097152,
        clip_limit:    25'd4194304,
        dc_limit:      25'd41943,
        level_ratio:   16'd25600,
        dropout_power: 50'd17592186
    };

    typedef struct packed {
        logic clear;
        logic write_sample;
        logic write_mag;
    } hist_ctl_t;

    typedef struct packed {
        logic accumulate;
        logic close;
    } acc_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/agm_f2q.sv
// ============================================================================
// agm_f2q: IEEE single to saturated signed fixed point
// Classifies NaN and infinity from the exponent and converts a finite word
// to a magnitude truncated toward zero and saturated, plus its signed value.
// ============================================================================
`default_nettype none

module agm_f2q #(
    parameter int FRAC_BITS = 22
) (
    input  wire logic [31:0]                       sample_bits,
    output logic signed [agm_pkg::VAL_W-1:0]       value,
    output logic [agm_pkg::MAG_W-1:0]              mag,
    output logic                                   is_nan,
    output logic                                   is_inf
);

    localparam logic signed [9:0] SH_OFS = 10'(FRAC_BITS - 150);

    logic [7:0]        expo;
    logic [22:0]       frac;
    logic [23:0]       sig;
    logic [7:0]        eff_e;
    logic signed [9:0] sh;
    logic [9:0]        rsh;
    logic [48:0]       lsh;
    logic [23:0]       rshv;

    always_comb
    begin
        expo  = sample_bits[30:23];
        frac  = sample_bits[22:0];
        sig   = {(expo != 8'd0), frac};
        eff_e = (expo == 8'd0) ? 8'd1 : expo;
        sh    = $signed({2'b00, eff_e}) + SH_OFS;
        rsh   = $unsigned(-sh);
        lsh   = {25'd0, sig} << sh[4:0];
        rshv  = sig >> rsh[4:0];

        if (sig == '0)
            mag = '0;
        else if (sh >= 10'sd26)
            mag = agm_pkg::VAL_MAX;
        else if (sh >= 10'sd0)
            mag = (lsh > 49'(agm_pkg::VAL_MAX)) ? agm_pkg::VAL_MAX : lsh[agm_pkg::MAG_W-1:0];
        else if (rsh >= 10'd24)
            mag = '0;
        else
            mag = agm_pkg::MAG_W'(rshv);

        value  = sample_bits[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        is_nan = (expo == 8'hFF) && (frac != '0);
        is_inf = (expo == 8'hFF) && (frac == '0);
    end

endmodule

`default_nettype wire

FILE: rtl/agm_hist.sv
// ============================================================================
// agm_hist: per-channel sample history
// Holds the previous sample and previous magnitude of each channel, returns
// the entry of the addressed channel and updates it as an item passes.
// ============================================================================
`default_nettype none

module agm_hist #(
    parameter int DEPTH = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                wr_en,
    input  wire agm_pkg::hist_ctl_t                  ctl,
    input  wire logic [agm_pkg::CH_W-1:0]            channel,
    input  wire logic signed [agm_pkg::VAL_W-1:0]    wr_value,
    input  wire logic [agm_pkg::MAG_W-1:0]           wr_mag,
    output logic signed [agm_pkg::VAL_W-1:0]         prev_value,
    output logic [agm_pkg::MAG_W-1:0]                prev_mag
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [IDX_W-1:0]                 idx;
    logic signed [agm_pkg::VAL_W-1:0] sample_reg [DEPTH];
    logic [agm_pkg::MAG_W-1:0]        mag_reg    [DEPTH];

    assign idx        = IDX_W'(channel);
    assign prev_value = sample_reg[idx];
    assign prev_mag   = mag_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                sample_reg[i] <= '0;
                mag_reg[i]    <= agm_pkg::MAG_RESET;
            end
        end
        else if (wr_en)
        begin
            if (ctl.clear)
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    sample_reg[i] <= '0;
                    mag_reg[i]    <= agm_pkg::MAG_RESET;
                end
            end
            else
            begin
                if (ctl.write_sample)
                    sample_reg[idx] <= wr_value;
                if (ctl.write_mag)
                    mag_reg[idx] <= wr_mag;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/agm_accum.sv
// ============================================================================
// agm_accum: per-channel block accumulators
// Counts samples and sums values and squares for each channel's block,
// stops growing at the block limit and restarts when a block closes.
// ============================================================================
`default_nettype none

module agm_accum #(
    parameter int DEPTH     = 8,
    parameter int MAX_BLOCK = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                wr_en,
    input  wire agm_pkg::acc_ctl_t                   ctl,
    input  wire logic [agm_pkg::CH_W-1:0]            channel,
    input  wire logic signed [agm_pkg::VAL_W-1:0]    value,
    input  wire logic [2*agm_pkg::MAG_W-1:0]         sq,
    output logic [$clog2(MAX_BLOCK+1)-1:0]           blk_count,
    output logic signed [agm_pkg::VAL_W+$clog2(MAX_BLOCK)-1:0] blk_sum,
    output logic [2*agm_pkg::MAG_W+$clog2(MAX_BLOCK)-1:0]      blk_power
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W = agm_pkg::VAL_W + $clog2(MAX_BLOCK);
    localparam int POW_W = 2 * agm_pkg::MAG_W + $clog2(MAX_BLOCK);

    logic [IDX_W-1:0]        idx;
    logic                    grow;
    logic [CNT_W-1:0]        cnt_reg [DEPTH];
    logic signed [SUM_W-1:0] sum_reg [DEPTH];
    logic [POW_W-1:0]        pow_reg [DEPTH];

    assign idx = IDX_W'(channel);

    always_comb
    begin
        grow      = ctl.accumulate && (cnt_reg[idx] < CNT_W'(MAX_BLOCK));
        blk_count = grow ? cnt_reg[idx] + CNT_W'(1) : cnt_reg[idx];
        blk_sum   = grow ? sum_reg[idx] + SUM_W'(value) : sum_reg[idx];
        blk_power = grow ? pow_reg[idx] + POW_W'(sq) : pow_reg[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                cnt_reg[i] <= '0;
                sum_reg[i] <= '0;
                pow_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            // block end: flags see the totals, storage restarts at zero
            if (ctl.close)
            begin
                cnt_reg[idx] <= '0;
                sum_reg[idx] <= '0;
                pow_reg[idx] <= '0;
            end
            else if (grow)
            begin
                cnt_reg[idx] <= blk_count;
                sum_reg[idx] <= blk_sum;
                pow_reg[idx] <= blk_power;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/audio_glitch_monitor.sv
// ============================================================================
// audio_glitch_monitor: per-sample audio glitch detector
// Input beats carry a float sample, its channel and a block end mark; each
// beat yields one result beat with the converted sample and glitch flags.
// ============================================================================
//
// Usage:
//   Input channel (in_valid / in_stall) takes one beat per cycle while not stalled.
//   Every beat, including a clear action or an out-of-range channel, returns exactly
//   one result beat on the output channel (out_valid / out_stall), in order.
//   Throughput is one beat per clock while out_stall is low, set by the
//   six-register pipeline: input register, conversion and history update,
//   multiply, accumulate, block products, output register. Same-channel beats
//   may follow back to back since history and accumulators each do their
//   read-modify-write within a single stage.
//   A stalled output holds its beat; empty stages behind it keep filling, and
//   in_stall rises only once all six stages hold beats.
//   Configuration writes (cfg_valid / cfg_ready, always ready) are registered
//   and must be issued only while no beat is in flight.
//   Reset: registers return to their defaults, previous samples to zero,
//   previous magnitudes to 42, block accumulators to zero; no clearing pass.
//
`default_nettype none

module audio_glitch_monitor #(
    parameter int CHANNELS  = 8,
    parameter int MAX_BLOCK = 4096,
    parameter int FRAC_BITS = 22
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [agm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [agm_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                action,
    input  wire logic [agm_pkg::CH_W-1:0]            channel,
    input  wire logic [31:0]                         sample_bits,
    input  wire logic                                block_end,

    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [agm_pkg::CH_W-1:0]                 out_channel,
    output logic signed [agm_pkg::VAL_W-1:0]         value,
    output logic                                     jump_flag,
    output logic                                     nan_flag,
    output logic                                     infinity_flag,
    output logic                                     clip_flag,
    output logic                                     level_flag,
    output logic                                     dc_flag,
    output logic                                     dropout_flag
);

    localparam int CH_W   = agm_pkg::CH_W;
    localparam int VAL_W  = agm_pkg::VAL_W;
    localparam int MAG_W  = agm_pkg::MAG_W;
    localparam int DEPTH  = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
    localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W  = VAL_W + $clog2(MAX_BLOCK);
    localparam int POW_W  = 2 * MAG_W + $clog2(MAX_BLOCK);
    localparam int ABS_W  = SUM_W - 1;
    localparam int NDC_W  = CNT_W + MAG_W;
    localparam int NPW_W  = CNT_W + agm_pkg::POWER_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int LVL_W  = MAG_W + agm_pkg::RATIO_W;
    localparam int DIFF_W = VAL_W + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    agm_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= agm_pkg::CFG_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            unique case (agm_pkg::cfg_reg_t'(cfg_index))
                agm_pkg::REG_ENABLE:
                    cfg_reg.enable_mask   <= cfg_data[agm_pkg::MASK_W-1:0];
                agm_pkg::REG_JUMP:
                    cfg_reg.jump_limit    <= cfg_data[MAG_W-1:0];
                agm_pkg::REG_CLIP:
                    cfg_reg.clip_limit    <= cfg_data[MAG_W-1:0];
                agm_pkg::REG_DC:
                    cfg_reg.dc_limit      <= cfg_data[MAG_W-1:0];
                agm_pkg::REG_LEVEL:
                    cfg_reg.level_ratio   <= cfg_data[agm_pkg::RATIO_W-1:0];
                agm_pkg::REG_DROPOUT:
                    cfg_reg.dropout_power <= cfg_data[agm_pkg::POWER_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline handshake: each stage loads when empty or when draining
    // ------------------------------------------------------------------
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4, rdyo;

    assign rdyo     = !vo_reg || !out_stall;
    assign rdy4     = !v4_reg || rdyo;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_stall = !rdy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= in_valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
            if (rdyo)
                vo_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 0: input register
    // ------------------------------------------------------------------
    logic            act0_reg;
    logic [CH_W-1:0] ch0_reg;
    logic [31:0]     bits0_reg;
    logic            end0_reg;

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            act0_reg  <= action;
            ch0_reg   <= channel;
            bits0_reg <= sample_bits;
            end0_reg  <= block_end;
        end
    end

    // ------------------------------------------------------------------
    // stage 0 -> 1: convert, classify, read and update history
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] conv_value;
    logic [MAG_W-1:0]        conv_mag;
    logic                    conv_nan, conv_inf;
    logic                    in_range0, smp0, live0, close0;
    logic [MAG_W-1:0]        m0;
    agm_pkg::hist_ctl_t      hist_ctl;
    logic signed [VAL_W-1:0] prev_value;
    logic [MAG_W-1:0]        prev_mag;

    agm_f2q #(
        .FRAC_BITS (FRAC_BITS)
    ) u_f2q (
        .sample_bits (bits0_reg),
        .value       (conv_value),
        .mag         (conv_mag),
        .is_nan      (conv_nan),
        .is_inf      (conv_inf)
    );

    always_comb
    begin
        in_range0             = 32'(ch0_reg) < 32'(DEPTH);
        smp0                  = !act0_reg && in_range0;
        live0                 = smp0 && !conv_nan && !conv_inf;
        close0                = smp0 && end0_reg;
        m0                    = (conv_mag == '0) ? MAG_W'(1) : conv_mag;
        hist_ctl.clear        = act0_reg;
        hist_ctl.write_sample = live0 && cfg_reg.enable_mask[agm_pkg::EN_JUMP];
        hist_ctl.write_mag    = live0 && cfg_reg.enable_mask[agm_pkg::EN_LEVEL];
    end

    agm_hist #(
        .DEPTH (DEPTH)
    ) u_hist (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (v0_reg && rdy1),
        .ctl        (hist_ctl),
        .channel    (ch0_reg),
        .wr_value   (conv_value),
        .wr_mag     (m0),
        .prev_value (prev_value),
        .prev_mag   (prev_mag)
    );

    logic [CH_W-1:0]         ch1_reg;
    logic                    live1_reg, close1_reg, nan1_reg, inf1_reg;
    logic signed [VAL_W-1:0] val1_reg, ps1_reg;
    logic [MAG_W-1:0]        mag1_reg, m1_reg, pm1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ch1_reg    <= ch0_reg;
            live1_reg  <= live0;
            close1_reg <= close0;
            nan1_reg   <= smp0 && conv_nan && cfg_reg.enable_mask[agm_pkg::EN_NONFIN];
            inf1_reg   <= smp0 && conv_inf && cfg_reg.enable_mask[agm_pkg::EN_NONFIN];
            val1_reg   <= live0 ? conv_value : '0;
            mag1_reg   <= live0 ? conv_mag : '0;
            m1_reg     <= m0;
            ps1_reg    <= prev_value;
            pm1_reg    <= prev_mag;
        end
    end

    // ------------------------------------------------------------------
    // stage 1 -> 2: square, level products, difference
    // ------------------------------------------------------------------
    logic [CH_W-1:0]          ch2_reg;
    logic                     live2_reg, close2_reg, nan2_reg, inf2_reg;
    logic signed [VAL_W-1:0]  val2_reg;
    logic [MAG_W-1:0]         mag2_reg, m2_reg, pm2_reg;
    logic [SQ_W-1:0]          sq2_reg;
    logic signed [DIFF_W-1:0] d2_reg;
    logic [LVL_W-1:0]         lm2_reg, lp2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            ch2_reg    <= ch1_reg;
            live2_reg  <= live1_reg;
            close2_reg <= close1_reg;
            nan2_reg   <= nan1_reg;
            inf2_reg   <= inf1_reg;
            val2_reg   <= val1_reg;
            mag2_reg   <= mag1_reg;
            m2_reg     <= m1_reg;
            pm2_reg    <= pm1_reg;
            sq2_reg    <= SQ_W'(mag1_reg) * SQ_W'(mag1_reg);
            d2_reg     <= DIFF_W'(val1_reg) - DIFF_W'(ps1_reg);
            lm2_reg    <= LVL_W'(m1_reg) * LVL_W'(cfg_reg.level_ratio);
            lp2_reg    <= LVL_W'(pm1_reg) * LVL_W'(cfg_reg.level_ratio);
        end
    end

    // ------------------------------------------------------------------
    // stage 2 -> 3: per-sample compares, block accumulation
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] jl2;
    logic                     jump_c, clip_c, level_c;
    agm_pkg::acc_ctl_t        acc_ctl;
    logic [CNT_W-1:0]         blk_count;
    logic signed [SUM_W-1:0]  blk_sum;
    logic [POW_W-1:0]         blk_power;

    always_comb
    begin
        jl2     = $signed({2'b00, cfg_reg.jump_limit});
        jump_c  = live2_reg && cfg_reg.enable_mask[agm_pkg::EN_JUMP]
                  && ((d2_reg > jl2) || (d2_reg < -jl2));
        clip_c  = live2_reg && cfg_reg.enable_mask[agm_pkg::EN_CLIP]
                  && (mag2_reg > cfg_reg.clip_limit);
        level_c = live2_reg && cfg_reg.enable_mask[agm_pkg::EN_LEVEL]
                  && (((LVL_W'(m2_reg) << agm_pkg::RATIO_FRAC) > lp2_reg)
                      || ((LVL_W'(pm2_reg) << agm_pkg::RATIO_FRAC) > lm2_reg));
        acc_ctl.accumulate = live2_reg;
        acc_ctl.close      = close2_reg;
    end

    agm_accum #(
        .DEPTH     (DEPTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (v2_reg && rdy3),
        .ctl       (acc_ctl),
        .channel   (ch2_reg),
        .value     (val2_reg),
        .sq        (sq2_reg),
        .blk_count (blk_count),
        .blk_sum   (blk_sum),
        .blk_power (blk_power)
    );

    logic [CH_W-1:0]         ch3_reg;
    logic signed [VAL_W-1:0] val3_reg;
    logic                    nan3_reg, inf3_reg, jump3_reg, clip3_reg, level3_reg;
    logic                    close3_reg;
    logic [CNT_W-1:0]        cnt3_reg;
    logic signed [SUM_W-1:0] sum3_reg;
    logic [POW_W-1:0]        pow3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            ch3_reg    <= ch2_reg;
            val3_reg   <= val2_reg;
            nan3_reg   <= nan2_reg;
            inf3_reg   <= inf2_reg;
            jump3_reg  <= jump_c;
            clip3_reg  <= clip_c;
            level3_reg <= level_c;
            close3_reg <= close2_reg;
            cnt3_reg   <= blk_count;
            sum3_reg   <= blk_sum;
            pow3_reg   <= blk_power;
        end
    end

    // ------------------------------------------------------------------
    // stage 3 -> 4: block threshold products, sum magnitude
    // ------------------------------------------------------------------
    logic [CH_W-1:0]         ch4_reg;
    logic signed [VAL_W-1:0] val4_reg;
    logic                    nan4_reg, inf4_reg, jump4_reg, clip4_reg, level4_reg;
    logic                    close4_reg;
    logic [ABS_W-1:0]        abs4_reg;
    logic [POW_W-1:0]        pow4_reg;
    logic [NDC_W-1:0]        ndc4_reg;
    logic [NPW_W-1:0]        npw4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            ch4_reg    <= ch3_reg;
            val4_reg   <= val3_reg;
            nan4_reg   <= nan3_reg;
            inf4_reg   <= inf3_reg;
            jump4_reg  <= jump3_reg;
            clip4_reg  <= clip3_reg;
            level4_reg <= level3_reg;
            close4_reg <= close3_reg;
            abs4_reg   <= ABS_W'(sum3_reg[SUM_W-1] ? -sum3_reg : sum3_reg);
            pow4_reg   <= pow3_reg;
            ndc4_reg   <= NDC_W'(cnt3_reg) * NDC_W'(cfg_reg.dc_limit);
            npw4_reg   <= NPW_W'(cnt3_reg) * NPW_W'(cfg_reg.dropout_power);
        end
    end

    // ------------------------------------------------------------------
    // stage 4 -> output register: block compares
    // ------------------------------------------------------------------
    logic [CH_W-1:0]         cho_reg;
    logic signed [VAL_W-1:0] valo_reg;
    logic                    jumpo_reg, nano_reg, info_reg, clipo_reg, levelo_reg;
    logic                    dco_reg, dropo_reg;

    always_ff @(posedge clk)
    begin
        if (rdyo)
        begin
            cho_reg    <= ch4_reg;
            valo_reg   <= val4_reg;
            jumpo_reg  <= jump4_reg;
            nano_reg   <= nan4_reg;
            info_reg   <= inf4_reg;
            clipo_reg  <= clip4_reg;
            levelo_reg <= level4_reg;
            dco_reg    <= close4_reg && cfg_reg.enable_mask[agm_pkg::EN_DC]
                          && (NDC_W'(abs4_reg) > ndc4_reg);
            dropo_reg  <= close4_reg && cfg_reg.enable_mask[agm_pkg::EN_DROP]
                          && (NPW_W'(pow4_reg) < npw4_reg);
        end
    end

    assign out_valid     = vo_reg;
    assign out_channel   = cho_reg;
    assign value         = valo_reg;
    assign jump_flag     = jumpo_reg;
    assign nan_flag      = nano_reg;
    assign infinity_flag = info_reg;
    assign clip_flag     = clipo_reg;
    assign level_flag    = levelo_reg;
    assign dc_flag       = dco_reg;
    assign dropout_flag  = dropo_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v0_reg && v1_reg && v2_reg && v3_reg && v4_reg && vo_reg && out_stall))
        else $error("input stalled while a pipeline stage was free");

    a_nonfinite_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (nan_flag || infinity_flag)) |->
            (value == '0 && !jump_flag && !clip_flag && !level_flag))
        else $error("non-finite sample carried a value or sample flags");

    a_result_from_stage4: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v4_reg))
        else $error("result appeared without a beat in the last stage");

endmodule

`default_nettype wire
